// ===== design/dmhs_pkg.sv =====
// Shared types and constants for the direct-mapped hash set.
package dmhs_pkg;

  // Table geometry
  localparam int SLOTS = 1024;
  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int MOD_W = IDX_W + 1;            // holds the modulus itself
  localparam int CFG_W = 11;

  // Hash mix constants
  localparam int          KEY_W    = 64;
  localparam int          HALF_W   = KEY_W / 2;
  localparam logic [63:0] HASH_MUL = 64'h2127599bf4325c37;
  localparam int          SHIFT_A  = 23;
  localparam int          SHIFT_B  = 47;

  // Remainder unit: DIGIT_W dividend bits per cycle
  localparam int DIGIT_W   = 4;
  localparam int MOD_STEPS = KEY_W / DIGIT_W;
  localparam int CNT_W     = (MOD_STEPS > 1) ? $clog2(MOD_STEPS) : 1;

  localparam int VALUE_W = 32;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_REMOVE = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    STAT_DONE      = 2'd0,
    STAT_REFUSED   = 2'd1,
    STAT_NOT_FOUND = 2'd2
  } status_t;

  typedef struct packed {
    op_t                        op;
    logic [KEY_W-1:0]           key;
    logic signed [VALUE_W-1:0]  value;
  } in_beat_t;

  typedef struct packed {
    logic    present;
    status_t status;
  } out_beat_t;

  typedef struct packed {
    logic               valid;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] data;
  } slot_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL0,
    ST_MUL1,
    ST_MUL2,
    ST_FOLD,
    ST_MOD,
    ST_READ,
    ST_RESOLVE
  } dmhs_state_t;

endpackage

// ===== design/direct_mapped_hash_set_top.sv =====
// Direct-mapped hash set: hash pipeline, remainder unit and slot memory.
// Usage:
//   Input channel (in_valid / in_stall / in_beat) carries one request beat:
//   insert, lookup or remove of a 64-bit key. Output channel (out_valid /
//   out_stall / out_beat) returns exactly one result beat per request, in
//   order: present flag and status code.
//   cfg_we / cfg_wdata set the bucket count; write it only while idle.
//   A count of 0 acts as 1, anything above SLOTS acts as SLOTS.
// Sequence and throughput:
//   One request is in flight at a time. From acceptance to out_valid a
//   request passes through three 32x32 partial products for the 64-bit
//   mix multiply (one shared multiplier), a fold step, the remainder unit
//   (4 dividend bits per cycle), a memory read and a resolve/write-back
//   step. The remainder unit takes the largest share of that time.
//   The next request is taken the cycle after resolve, even while the
//   result still waits in the output register.
// Reset: rst_n is synchronous, active low. The block then sweeps the slot
//   memory marking all SLOTS (1024) slots empty, in_stall high.
// Stall: the result beat is held in an output register. If out_stall keeps
//   it there, the next request parks in the resolve step until it drains.
module direct_mapped_hash_set_top
  import dmhs_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_beat_t         in_beat,
  output logic             out_valid,
  input  logic             out_stall,
  output out_beat_t        out_beat,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata
);

  // Slot memory, read data registered
  slot_t slot_mem [SLOTS];
  slot_t rd_data_r;

  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  slot_t            mem_wdata;
  logic             mem_re;

  // Control and working registers
  dmhs_state_t         state_r, state_nxt;
  logic [IDX_W-1:0]    clr_r, clr_nxt;
  logic [CFG_W-1:0]    cfg_r;
  op_t                 op_r;
  logic [KEY_W-1:0]    key_r;
  logic [VALUE_W-1:0]  value_r;
  logic [KEY_W-1:0]    x_r;                 // key after first xor-shift
  logic [KEY_W-1:0]    acc_r, acc_nxt;      // product accumulator
  logic [KEY_W-1:0]    dvd_r, dvd_nxt;      // remaining dividend bits
  logic [IDX_W-1:0]    rem_r, rem_nxt;      // running remainder = bucket
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_beat_t           out_beat_r, out_beat_nxt;

  logic                 accept;
  logic [MOD_W-1:0]     eff_mod;
  logic [HALF_W-1:0]    mul_a, mul_b;
  logic [KEY_W-1:0]     prod;
  logic [IDX_W-1:0]     rem_step;
  logic                 hit;
  logic                 out_free;

  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;
  assign out_free  = !out_valid_r || !out_stall;

  // Effective modulus
  always_comb begin
    if (cfg_r == '0) begin
      eff_mod = MOD_W'(1);
    end else if (32'(cfg_r) > SLOTS) begin
      eff_mod = MOD_W'(SLOTS);
    end else begin
      eff_mod = MOD_W'(cfg_r);
    end
  end

  // Shared 32x32 multiplier for the partial products of x * HASH_MUL
  always_comb begin
    mul_a = x_r[HALF_W-1:0];
    mul_b = HASH_MUL[HALF_W-1:0];
    case (state_r)
      ST_MUL1: begin
        mul_a = x_r[KEY_W-1:HALF_W];
      end
      ST_MUL2: begin
        mul_b = HASH_MUL[KEY_W-1:HALF_W];
      end
      default: begin
      end
    endcase
  end
  assign prod = KEY_W'(mul_a) * KEY_W'(mul_b);

  // One remainder step: DIGIT_W restoring compare-subtract stages
  always_comb begin
    logic [MOD_W-1:0] trial;
    logic [IDX_W-1:0] r;
    r = rem_r;
    for (int i = 0; i < DIGIT_W; i++) begin
      trial = {r, dvd_r[KEY_W-1-i]};
      if (trial >= eff_mod) begin
        trial = trial - eff_mod;
      end
      r = trial[IDX_W-1:0];
    end
    rem_step = r;
  end

  assign hit = rd_data_r.valid && (rd_data_r.key == key_r);

  // Next state and outputs
  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    acc_nxt       = acc_r;
    dvd_nxt       = dvd_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_beat_nxt  = out_beat_r;
    mem_we        = 1'b0;
    mem_waddr     = rem_r;
    mem_wdata     = rd_data_r;
    mem_re        = 1'b0;

    unique case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = '0;
        clr_nxt   = clr_r + 1'b1;
        if (clr_r == IDX_W'(SLOTS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_MUL0;
        end
      end
      ST_MUL0: begin
        acc_nxt   = prod;
        state_nxt = ST_MUL1;
      end
      ST_MUL1: begin
        acc_nxt   = {acc_r[KEY_W-1:HALF_W] + prod[HALF_W-1:0], acc_r[HALF_W-1:0]};
        state_nxt = ST_MUL2;
      end
      ST_MUL2: begin
        acc_nxt   = {acc_r[KEY_W-1:HALF_W] + prod[HALF_W-1:0], acc_r[HALF_W-1:0]};
        state_nxt = ST_FOLD;
      end
      ST_FOLD: begin
        dvd_nxt   = acc_r ^ (acc_r >> SHIFT_B);
        rem_nxt   = '0;
        cnt_nxt   = '0;
        state_nxt = ST_MOD;
      end
      ST_MOD: begin
        rem_nxt = rem_step;
        dvd_nxt = dvd_r << DIGIT_W;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(MOD_STEPS - 1)) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        mem_re    = 1'b1;
        state_nxt = ST_RESOLVE;
      end
      ST_RESOLVE: begin
        if (out_free) begin
          out_valid_nxt        = 1'b1;
          out_beat_nxt.present = 1'b0;
          out_beat_nxt.status  = STAT_DONE;
          case (op_r)
            OP_INSERT: begin
              if (rd_data_r.valid) begin
                out_beat_nxt.status = STAT_REFUSED;
              end else begin
                mem_we          = 1'b1;
                mem_wdata.valid = 1'b1;
                mem_wdata.key   = key_r;
                mem_wdata.data  = value_r;
              end
            end
            OP_LOOKUP: begin
              if (hit) begin
                out_beat_nxt.present = 1'b1;
              end else begin
                out_beat_nxt.status = STAT_NOT_FOUND;
              end
            end
            OP_REMOVE: begin
              if (hit) begin
                out_beat_nxt.present = 1'b1;
                mem_we               = 1'b1;
                mem_wdata.valid      = 1'b0;
              end else begin
                out_beat_nxt.status = STAT_NOT_FOUND;
              end
            end
            default: begin
              // unused op code: no state change, plain done
            end
          endcase
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      cfg_r       <= CFG_W'(1024);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        cfg_r <= cfg_wdata;
      end
    end
  end

  // Payload and datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r    <= in_beat.op;
      key_r   <= in_beat.key;
      value_r <= in_beat.value;
      x_r     <= in_beat.key ^ (in_beat.key >> SHIFT_A);
    end
    acc_r      <= acc_nxt;
    dvd_r      <= dvd_nxt;
    rem_r      <= rem_nxt;
    cnt_r      <= cnt_nxt;
    out_beat_r <= out_beat_nxt;
  end

  // Slot memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= slot_mem[rem_r];
    end
  end

endmodule

// ===== design/dmhs_checker.sv =====
// Port-level checks for the direct-mapped hash set, bound to the top level.
module dmhs_checker
  import dmhs_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_beat_t out_beat
);

  // held result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_beat))
    else $error("stalled result beat changed");

  // one request in flight
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second request taken while one is in flight");

  // a hit is always reported as done
  a_hit_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_beat.present |-> out_beat.status == STAT_DONE)
    else $error("present set with a failure status");

  // clearing sweep follows reset
  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> in_stall)
    else $error("request channel open right after reset");

endmodule

bind direct_mapped_hash_set_top dmhs_checker u_dmhs_checker (.*);
